FILE: src/adcsfc_pkg.sv
`default_nettype none

package adcsfc_pkg;

    localparam int ROWS     = 256;
    localparam int CHANNELS = 6;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int DEPTH    = ROWS * CHANNELS;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int S_DATA_W = 64;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = 3;
    localparam int M_BODY_W = 75;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [ADDR_W-1:0] t_addr;

    // Frame held between the table write and the fill write-back
    typedef struct packed {
        t_row        row;
        logic [31:0] word;
        logic        fill;
        t_chan       fill_ch;
        logic        adv;
        logic        err;
    } t_b_stage;

    function automatic t_addr entry_addr(input t_row row, input t_chan ch);
        return ADDR_W'(row) * ADDR_W'(CHANNELS) + ADDR_W'(ch);
    endfunction

    function automatic logic [7:0] row_byte(input t_row row);
        logic [ROW_W+7:0] wide;
        wide = {8'd0, row};
        return wide[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/adc_scan_frame_capture_top.sv
// Scan-frame capture: one converter frame in, one result out. The sample memory
// has a single write port and a frame may need two writes (its own sample and the
// fill of a missed channel from the previous row), so the block takes no new frame
// while the previous one sits in the write-back stage; a result leaves through an
// output register that is loaded from that stage.
// After reset the sample and frequency tables are cleared one entry per cycle:
// tready stays low until all ROWS*CHANNELS = 1536 sample entries are cleared.
`default_nettype none

module adc_scan_frame_capture_top import adcsfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // sign_nibble[3:0], data_upper[11:4], data_high[19:12], data_low[27:20],
    // freq_word[59:28], zero pad above
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // chan_id[3:0]
    input  logic [S_USER_W-1:0] i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // row_index[7:0], sample_word[39:8], fill_channel[42:40], fill_value[74:43],
    // zero pad above
    output logic [M_DATA_W-1:0] o_m_tdata,
    // fill_done[0], row_advanced[1], channel_error[2]
    output logic [M_USER_W-1:0] o_m_tuser
);

    localparam logic [3:0] CHAN_LIMIT = 4'(CHANNELS);

    logic [31:0] mem_sample [DEPTH];
    logic [31:0] mem_freq   [ROWS];

    logic        r_init_done;
    t_addr       r_clr_addr;
    t_row        r_row;
    t_chan       r_exp;
    logic        r_b_valid;
    t_b_stage    r_b;
    logic [31:0] r_rd_data;
    logic        r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    logic [3:0]  in_chan;
    logic [31:0] in_word;
    logic [31:0] in_freq;
    logic        chan_ok;
    t_chan       ch;
    logic        is_zero;
    logic        mismatch;
    logic        row_last;
    t_row        prev_row;
    t_addr       wr_addr;
    t_addr       rd_addr;
    t_addr       fill_addr;
    logic        s_fire;
    logic        b_move;
    logic [31:0] fill_value;
    t_b_stage    n_b;

    assign in_chan  = i_s_tuser[3:0];
    assign in_word  = {i_s_tdata[3:0], i_s_tdata[3:0], i_s_tdata[11:4],
                       i_s_tdata[19:12], i_s_tdata[27:20]};
    assign in_freq  = i_s_tdata[59:28];
    assign chan_ok  = in_chan < CHAN_LIMIT;
    assign ch       = in_chan[CH_W-1:0];
    assign is_zero  = ch == '0;
    assign mismatch = ch != r_exp;
    assign row_last = r_row == t_row'(ROWS - 1);
    assign prev_row = (r_row == '0) ? t_row'(ROWS - 1) : r_row - 1'b1;

    assign wr_addr   = entry_addr(r_row, ch);
    assign rd_addr   = entry_addr(prev_row, r_exp);
    assign fill_addr = entry_addr(r_b.row, r_b.fill_ch);

    assign o_s_tready = r_init_done && !r_b_valid;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign b_move     = r_b_valid && (!r_out_valid || i_m_tready);
    assign fill_value = r_b.fill ? r_rd_data : 32'd0;

    always_comb begin
        n_b.row     = r_row;
        n_b.word    = in_word;
        n_b.fill    = chan_ok && mismatch;
        n_b.fill_ch = (chan_ok && mismatch) ? r_exp : '0;
        n_b.adv     = chan_ok && is_zero && !row_last;
        n_b.err     = !chan_ok;
    end

    // Sample memory: clear sweep, frame write, then fill write-back
    always_ff @(posedge i_clk) begin
        if (!r_init_done) begin
            if (i_rst_n) begin
                mem_sample[r_clr_addr] <= '0;
            end
        end else if (s_fire && chan_ok) begin
            mem_sample[wr_addr] <= in_word;
        end else if (b_move && r_b.fill) begin
            mem_sample[fill_addr] <= r_rd_data;
        end
        if (s_fire) begin
            r_rd_data <= mem_sample[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_init_done) begin
            if (i_rst_n && r_clr_addr < t_addr'(ROWS)) begin
                mem_freq[r_clr_addr[ROW_W-1:0]] <= '0;
            end
        end else if (s_fire && chan_ok && is_zero) begin
            mem_freq[r_row] <= in_freq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_done <= 1'b0;
            r_clr_addr  <= '0;
            r_row       <= '0;
            r_exp       <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_init_done) begin
                if (r_clr_addr == t_addr'(DEPTH - 1)) begin
                    r_init_done <= 1'b1;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (s_fire && chan_ok) begin
                r_exp <= is_zero ? t_chan'(CHANNELS - 1) : ch - 1'b1;
                if (is_zero && !row_last) begin
                    r_row <= r_row + 1'b1;
                end
            end
            if (s_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_b <= n_b;
        end
        if (b_move) begin
            r_out_data <= {{(M_DATA_W - M_BODY_W){1'b0}}, fill_value,
                           3'(r_b.fill_ch), r_b.word, row_byte(r_b.row)};
            r_out_user <= {r_b.err, r_b.adv, r_b.fill};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_b_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_b_valid)
        else $error("accepted frame did not enter the write-back stage");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && chan_ok && is_zero && !row_last |=> r_row == $past(r_row) + 1'b1)
        else $error("row did not advance on channel zero");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> !o_m_tuser[0] && !o_m_tuser[1])
        else $error("dropped frame reports fill or row advance");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_init_done |-> !s_fire && !r_b_valid && !r_out_valid)
        else $error("frame activity during table clear");

endmodule

`default_nettype wire
